FILE: rtl/core/gpt_pkg.sv
package gpt_pkg;

  // 2*ln(2) in Q.30, rounded to nearest
  localparam logic [30:0] TWO_LN2_Q30 = 31'h58B90BFC;
  localparam int Q_FRAC = 30;

  // back-end datapath widths
  localparam int NRM_W  = 64;   // normalizer word, holds Q left aligned
  localparam int LZ_W   = 6;
  localparam int X_W    = 31;   // Q1.30 mantissa and Q.30 ratio
  localparam int FRAC_W = 30;
  localparam int Y_W    = 38;
  localparam int P1_W   = 39;
  localparam int P2_W   = 61;
  localparam int V_W    = 62;
  localparam int RT_W   = 63;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [31:0] SAT_POS = 32'h7FFFFFFF;
  localparam logic [31:0] SAT_NEG = 32'h80000000;

endpackage

FILE: rtl/core/gaussian_polar_transform.sv
// Marsaglia polar Gaussian transform, one attempt per sample beat.
// Sample channel: sample_valid/sample_ready with two raw uniform words
// sample_u and sample_v. Normal channel: normal_valid/normal_ready with
// normal_value, a signed deviate with OUT_FRAC_BITS fraction bits,
// saturated at the 32-bit limits.
// Attempts on or outside the unit circle, and the origin, give no beat.
// Throughput: one sample beat per cycle while the receiver takes beats.
// Stages: the back pipeline has 6 normalize, 30 log2 squaring, 5 scale
// and product stages and 31 square-root steps, and two front stages
// and the queue come before it.
// A front section maps, squares and classifies; a 4-entry queue feeds
// the back pipeline, so sample_ready drops only when the queue is full.
// When normal_valid is high and normal_ready is low the back pipeline
// holds in place and the front keeps filling the queue.
// Reset (rst, synchronous) empties the pipeline and the queue; no
// deviate is lost or repeated across a stall.
module gaussian_polar_transform #(
  parameter int UNIFORM_BITS  = 31,
  parameter int OUT_FRAC_BITS = 26
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  logic [UNIFORM_BITS-1:0] sample_u,
  input  logic [UNIFORM_BITS-1:0] sample_v,
  output logic                    normal_valid,
  input  logic                    normal_ready,
  output logic [31:0]             normal_value
);

  localparam int EW = 4 * UNIFORM_BITS - 3;

  logic          full;
  logic          push;
  logic [EW-1:0] push_data;
  logic          pop;
  logic [EW-1:0] head;
  logic          empty;

  gpt_front #(
    .UNIFORM_BITS(UNIFORM_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_u     (sample_u),
    .sample_v     (sample_v),
    .full         (full),
    .push         (push),
    .push_data    (push_data)
  );

  gpt_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  gpt_back #(
    .UNIFORM_BITS  (UNIFORM_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .normal_valid (normal_valid),
    .normal_ready (normal_ready),
    .normal_value (normal_value)
  );

endmodule

FILE: rtl/core/gpt_front.sv
module gpt_front #(
  parameter int UNIFORM_BITS = 31
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_ready,
  input  logic [UNIFORM_BITS-1:0]   sample_u,
  input  logic [UNIFORM_BITS-1:0]   sample_v,
  input  logic                      full,
  output logic                      push,
  output logic [4*UNIFORM_BITS-4:0] push_data
);

  localparam int F  = UNIFORM_BITS - 1;
  localparam int QW = 2 * F;
  localparam int MW = F + 1;
  localparam logic [MW-1:0] HALF = MW'(1) << F;

  logic          s1_vld;
  logic          s1_neg;
  logic [MW-1:0] s1_ma;
  logic [MW-1:0] s1_mb;
  logic            s2_vld;
  logic            s2_neg;
  logic [2*MW-1:0] s2_a2;
  logic [2*MW-1:0] s2_b2;
  logic [2*MW:0]   sum;
  logic            keep;
  logic            adv;

  assign sum  = {1'b0, s2_a2} + {1'b0, s2_b2};
  // drop the origin and everything on or outside the unit circle
  assign keep = (sum != '0) && (sum[2*MW:QW] == '0);
  assign adv  = !(s2_vld && keep && full);

  assign sample_ready = adv;
  assign push         = s2_vld && keep && !full;
  assign push_data    = {s2_neg, s2_a2[QW-1:0], sum[QW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= sample_valid;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg <= sample_u < HALF;
      s1_ma  <= (sample_u < HALF) ? HALF - sample_u : sample_u - HALF;
      s1_mb  <= (sample_v < HALF) ? HALF - sample_v : sample_v - HALF;
      s2_neg <= s1_neg;
      s2_a2  <= (2*MW)'(s1_ma) * (2*MW)'(s1_ma);
      s2_b2  <= (2*MW)'(s1_mb) * (2*MW)'(s1_mb);
    end
  end

endmodule

FILE: rtl/core/gpt_queue.sv
module gpt_queue import gpt_pkg::*; #(
  parameter int WIDTH = 121
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full   = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty  = count == '0;
  assign head   = mem[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue push while full");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

FILE: rtl/core/gpt_back.sv
module gpt_back import gpt_pkg::*; #(
  parameter int UNIFORM_BITS  = 31,
  parameter int OUT_FRAC_BITS = 26
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [4*UNIFORM_BITS-4:0] head,
  input  logic                      empty,
  output logic                      pop,
  output logic                      normal_valid,
  input  logic                      normal_ready,
  output logic [31:0]               normal_value
);

  localparam int F  = UNIFORM_BITS - 1;
  localparam int QW = 2 * F;

  // stage map: normalize 1..6, squarings 7..36, long division 1..31,
  // -ln scaling 37..38, ratio product 39..40, saturate 41, isqrt 42..72
  localparam int NORM_ST  = 6;
  localparam int LOG_END  = NORM_ST + FRAC_W;
  localparam int DIV_END  = X_W;
  localparam int LM_ST    = LOG_END + 1;
  localparam int LY_ST    = LOG_END + 2;
  localparam int WM_ST    = LOG_END + 3;
  localparam int WS_ST    = LOG_END + 4;
  localparam int SAT_ST   = LOG_END + 5;
  localparam int SQ0_ST   = SAT_ST + 1;
  localparam int NS       = SAT_ST + V_W / 2;
  localparam int SAT_E    = 92 - 2 * OUT_FRAC_BITS;
  localparam int V_SH     = 2 * OUT_FRAC_BITS - 30;

  typedef struct packed {
    logic              vld;
    logic              neg;
    logic              sat;
    logic [NRM_W-1:0]  nrm;
    logic [LZ_W-1:0]   lz;
    logic [X_W-1:0]    x;
    logic [FRAC_W-1:0] frac;
    logic [QW-1:0]     den;
    logic [QW:0]       rem;
    logic [X_W-1:0]    ratio;
    logic [P1_W-1:0]   p1;
    logic [P2_W-1:0]   p2;
    logic [Y_W-1:0]    y;
    logic [Y_W-1:0]    w;
    logic [V_W-1:0]    v;
    logic [RT_W-1:0]   root;
  } bk_t;

  bk_t         src [0:NS];
  bk_t         nx  [1:NS];
  bk_t         stg [1:NS];
  logic        en;
  logic [31:0] mag;

  assign en  = !normal_valid || normal_ready;
  assign pop = en && !empty;

  always_comb begin
    src[0]      = '0;
    src[0].vld  = !empty;
    src[0].neg  = head[2*QW];
    src[0].den  = head[QW-1:0];
    src[0].rem  = {1'b0, head[2*QW-1:QW]};
    src[0].nrm  = NRM_W'(head[QW-1:0]) << (NRM_W - QW);
  end

  for (genvar k = 1; k <= NS; k++) begin : g_st
    localparam int SH = (k <= NORM_ST) ? (1 << (NORM_ST - k)) : 1;
    localparam int BE = (k >= SQ0_ST) ? (V_W - 2 - 2 * (k - SQ0_ST)) : 0;

    assign src[k] = stg[k];

    always_comb begin
      logic [2*X_W-1:0] sq;
      logic [X_W:0]     t;
      logic [QW:0]      rs;
      logic             ge;
      logic [LZ_W:0]    hi_l;
      logic [FRAC_W-1:0] lo_l;
      logic [RT_W-1:0]  bitv;
      logic [RT_W-1:0]  sum;
      logic             sge;

      nx[k] = src[k-1];
      sq    = '0;
      t     = '0;
      rs    = '0;
      ge    = 1'b0;
      hi_l  = '0;
      lo_l  = '0;
      bitv  = '0;
      sum   = '0;
      sge   = 1'b0;

      if (k <= NORM_ST) begin
        if (src[k-1].nrm[NRM_W-1 -: SH] == '0) begin
          nx[k].nrm = src[k-1].nrm << SH;
          nx[k].lz  = src[k-1].lz + LZ_W'(SH);
        end
        nx[k].x = nx[k].nrm[NRM_W-1 -: X_W];
      end else if (k <= LOG_END) begin
        // one fraction bit of log2 per squaring
        sq         = (2*X_W)'(src[k-1].x) * (2*X_W)'(src[k-1].x);
        t          = sq[2*X_W-1:Q_FRAC];
        nx[k].x    = t[X_W] ? t[X_W:1] : t[X_W-1:0];
        nx[k].frac = {src[k-1].frac[FRAC_W-2:0], t[X_W]};
      end

      if (k <= DIV_END) begin
        rs           = (k == 1) ? src[k-1].rem : {src[k-1].rem[QW-1:0], 1'b0};
        ge           = rs >= {1'b0, src[k-1].den};
        nx[k].rem    = ge ? rs - {1'b0, src[k-1].den} : rs;
        nx[k].ratio  = {src[k-1].ratio[X_W-2:0], ge};
      end

      if (k == LM_ST) begin
        // L = (lz+1)*2^30 - frac, split into integer and fraction parts
        hi_l     = (LZ_W+1)'(src[k-1].lz) + (LZ_W+1)'(1)
                   - (LZ_W+1)'(src[k-1].frac != '0);
        lo_l     = (src[k-1].frac != '0) ? FRAC_W'(~src[k-1].frac + 1'b1) : '0;
        nx[k].p1 = P1_W'(hi_l) * P1_W'(TWO_LN2_Q30);
        nx[k].p2 = P2_W'(lo_l) * P2_W'(TWO_LN2_Q30);
      end else if (k == LY_ST) begin
        nx[k].y = Y_W'(src[k-1].p1) + Y_W'(src[k-1].p2 >> Q_FRAC);
      end else if (k == WM_ST) begin
        nx[k].p1 = P1_W'(src[k-1].y[Y_W-1:Q_FRAC]) * P1_W'(src[k-1].ratio);
        nx[k].p2 = P2_W'(src[k-1].y[Q_FRAC-1:0]) * P2_W'(src[k-1].ratio);
      end else if (k == WS_ST) begin
        nx[k].w = Y_W'(src[k-1].p1 + P1_W'(src[k-1].p2 >> Q_FRAC));
      end else if (k == SAT_ST) begin
        nx[k].sat  = 64'(src[k-1].w) >= (64'd1 << SAT_E);
        nx[k].v    = V_W'(src[k-1].w) << V_SH;
        nx[k].root = '0;
      end else if (k >= SQ0_ST) begin
        bitv = RT_W'(1) << BE;
        sum  = src[k-1].root + bitv;
        sge  = {1'b0, src[k-1].v} >= sum;
        if (sge) begin
          nx[k].v    = src[k-1].v - sum[V_W-1:0];
          nx[k].root = (src[k-1].root >> 1) + bitv;
        end else begin
          nx[k].root = src[k-1].root >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k].vld <= 1'b0;
      end else if (en) begin
        stg[k] <= nx[k];
      end
    end
  end

  assign mag = stg[NS].root[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
    end else if (en) begin
      normal_valid <= stg[NS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (stg[NS].sat) normal_value <= stg[NS].neg ? SAT_NEG : SAT_POS;
      else normal_value <= stg[NS].neg ? (32'd0 - mag) : mag;
    end
  end

  a_norm_top: assert property (@(posedge clk) disable iff (rst)
    stg[NORM_ST].vld |-> stg[NORM_ST].nrm[NRM_W-1])
    else $error("normalizer left Q unaligned");
  a_log_range: assert property (@(posedge clk) disable iff (rst)
    stg[LOG_END].vld |-> stg[LOG_END].x[X_W-1])
    else $error("log mantissa out of [1,2)");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    stg[DIV_END].vld |-> (stg[DIV_END].rem < {1'b0, stg[DIV_END].den}))
    else $error("division remainder not below divisor");

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] TWO_LN2 = 64'h58B90BFC;
  localparam logic [30:0] HALF    = 31'h40000000;
  localparam logic [30:0] TOP     = 31'h7FFFFFFE;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  logic [30:0] sample_u = '0;
  logic [30:0] sample_v = '0;
  logic        normal_valid;
  logic        normal_ready = 1'b0;
  logic [31:0] normal_value;

  logic [31:0] expected_normals[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  gaussian_polar_transform DUT (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready),
    .sample_u(sample_u), .sample_v(sample_v),
    .normal_valid(normal_valid), .normal_ready(normal_ready),
    .normal_value(normal_value)
  );

  function automatic logic [63:0] scale_q30(logic [63:0] big, logic [63:0] factor);
    scale_q30 = (big >> 30) * factor + (((big & 64'h3FFFFFFF) * factor) >> 30);
  endfunction

  // one polar attempt; hit is low when the point is rejected
  function automatic void polar_deviate(input logic [30:0] ru, input logic [30:0] rv,
                                        output bit hit, output logic [31:0] z);
    logic [63:0] ma, mb, a2, q, x, frac, l, y, rem, ratio, w, v, res, bt;
    int p;
    bit neg;
    neg = ru < HALF;
    ma = neg ? 64'(HALF - ru) : 64'(ru - HALF);
    mb = (rv < HALF) ? 64'(HALF - rv) : 64'(rv - HALF);
    a2 = ma * ma;
    q = a2 + mb * mb;
    hit = 0;
    z = '0;
    if (q == 0 || q >= (64'd1 << 60)) return;
    hit = 1;
    p = 0;
    for (int i = 0; i < 64; i++) if (q[i]) p = i;
    x = (p > 30) ? (q >> (p - 30)) : (q << (30 - p));
    frac = 0;
    for (int i = 0; i < 30; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        frac = frac | 1;
        x = x >> 1;
      end
    end
    l = (64'(60 - p) << 30) - frac;
    y = scale_q30(l, TWO_LN2);
    rem = a2;
    ratio = 0;
    if (rem >= q) begin
      ratio = 1;
      rem = rem - q;
    end
    for (int i = 0; i < 30; i++) begin
      rem = rem << 1;
      ratio = ratio << 1;
      if (rem >= q) begin
        rem = rem - q;
        ratio = ratio | 1;
      end
    end
    w = scale_q30(y, ratio);
    if (w >= (64'd1 << 40)) begin
      z = neg ? 32'h80000000 : 32'h7FFFFFFF;
      return;
    end
    v = w << 22;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    z = neg ? 32'(-res) : res[31:0];
  endfunction

  task automatic send_sample(logic [30:0] u, logic [30:0] v);
    bit hit;
    logic [31:0] z;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_u <= u;
    sample_v <= v;
    @(negedge clk);
    while (!sample_ready) @(negedge clk);
    @(posedge clk);
    polar_deviate(u, v, hit, z);
    if (hit) expected_normals.push_back(z);
  endtask

  function automatic logic [30:0] random_word();
    case ($urandom_range(9))
      0: random_word = HALF + 31'($urandom_range(2000)) - 31'd1000;
      1: random_word = $urandom_range(1) ? TOP - 31'($urandom_range(50)) : 31'($urandom_range(50));
      default: random_word = 31'($urandom_range(32'h7FFFFFFE));
    endcase
  endfunction

  task automatic test_directed();
    send_sample(HALF, HALF);           // origin
    send_sample(31'd0, 31'd0);         // corner, outside
    send_sample(TOP, TOP);
    send_sample(31'd0, HALF);          // exactly on the circle
    send_sample(HALF, 31'd0);
    send_sample(31'd1, HALF);
    send_sample(TOP, HALF);
    send_sample(HALF + 31'd1, HALF);   // tiny S, largest positive deviate
    send_sample(HALF - 31'd1, HALF);   // largest negative deviate
    send_sample(HALF, HALF + 31'd1);   // u = 0
    send_sample(HALF + 31'd1, HALF + 31'd1);
    send_sample(31'h20000000, 31'h20000000);
    send_sample(31'h60000000, 31'h20000000);
    send_sample(31'h55555555, 31'h2AAAAAAA);
    send_sample(31'h2AAAAAAA, 31'h55555555);
    send_sample(HALF + 31'd100000, HALF - 31'd3);
    send_sample(31'h0FFFFFFF, HALF);
    send_sample(31'h70000000, 31'h3FFFFFFF);
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_sample(random_word(), random_word());
  endtask

  // enough kept beats to fill the back pipeline and the queue
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    repeat (130) send_sample(random_word(), random_word());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      normal_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      normal_ready <= 1'b0;
    end else begin
      normal_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && normal_valid && normal_ready) begin
      if (expected_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: normal_value=%h", normal_value);
      end else begin
        if (normal_value !== expected_normals[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("normal_value: expected %h, got %h", expected_normals[0], normal_value);
        end
        void'(expected_normals.pop_front());
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (normal_valid && normal_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(160, 0, 0);
    test_random(150, 56, 0);
    test_random(150, 0, 56);
    test_random(150, 7, 7);
    test_backpressure();
    sample_valid <= 1'b0;
    recv_stall_pct = 0;
    wait (expected_normals.size() == 0);
    repeat (150) @(posedge clk);
    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: gaussian_polar_transform.f
rtl/core/gpt_pkg.sv
rtl/core/gpt_front.sv
rtl/core/gpt_queue.sv
rtl/core/gpt_back.sv
rtl/core/gaussian_polar_transform.sv
tb/tb.sv
